// ===== design/cbm_pkg.sv =====
// ---------------------------------------------------------------------------
// cbm_pkg
// shared types, field widths and width helpers for the color balance
// matrix chain
// ---------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

   localparam int PIX_WIDTH       = 8;
   localparam int HUE_WIDTH       = 14;
   localparam int GAIN_WIDTH      = 15;
   localparam int CSR_INDEX_WIDTH = 3;
   localparam int CSR_DATA_WIDTH  = 15;
   localparam int NUM_CH          = 3;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_HUE_COS         = 3'd0,
      CSR_HUE_SIN         = 3'd1,
      CSR_SATURATION_GAIN = 3'd2,
      CSR_BRIGHTNESS_GAIN = 3'd3,
      CSR_CONTRAST_GAIN   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                       en;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [CSR_DATA_WIDTH-1:0]  data;
   } csr_write_type;

   function automatic int max_int(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

   // hue matrix entries: bounded by the 14-bit cos/sin range or by 1.0
   function automatic int coef_width(input int f);
      return max_int(f, 13) + 3;
   endfunction

   // luminance weights (1 - sat) * lum, sat up to 15 bits
   function automatic int weight_width(input int f);
      return max_int(f, 15) + 2;
   endfunction

   // contrast offset with the rounding half folded in
   function automatic int offset_width(input int f);
      return weight_width(f) + f + 9;
   endfunction

endpackage

`default_nettype wire

// ===== design/cbm_coef.sv =====
// ---------------------------------------------------------------------------
// cbm_coef
// control registers and the matrix coefficients derived from them
// ---------------------------------------------------------------------------
`default_nettype none

module cbm_coef #(
   parameter int COEF_FRAC_BITS = 12
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire cbm_pkg::csr_write_type                  csr_wr,
   output logic signed [cbm_pkg::coef_width(COEF_FRAC_BITS)-1:0]   hue_a,
   output logic signed [cbm_pkg::coef_width(COEF_FRAC_BITS)-1:0]   hue_b,
   output logic signed [cbm_pkg::coef_width(COEF_FRAC_BITS)-1:0]   hue_c,
   output logic signed [cbm_pkg::weight_width(COEF_FRAC_BITS)-1:0] lum_r,
   output logic signed [cbm_pkg::weight_width(COEF_FRAC_BITS)-1:0] lum_g,
   output logic signed [cbm_pkg::weight_width(COEF_FRAC_BITS)-1:0] lum_b,
   output logic [cbm_pkg::GAIN_WIDTH-1:0]               sat_gain,
   output logic [cbm_pkg::GAIN_WIDTH-1:0]               bri_gain,
   output logic [cbm_pkg::GAIN_WIDTH-1:0]               con_gain,
   output logic signed [cbm_pkg::offset_width(COEF_FRAC_BITS)-1:0] con_off
);
   import cbm_pkg::*;

   localparam int F   = COEF_FRAC_BITS;
   localparam int CW  = coef_width(F);
   localparam int WW  = weight_width(F);
   localparam int OW  = offset_width(F);
   localparam int TPW = CW + F + 2;
   localparam int LPW = WW + F + 2;
   localparam int KW  = F + 2;

   localparam longint ONE_L     = longint'(1) <<< F;
   localparam longint THIRD_FX  = ((longint'(333333) <<< F) + 500000) / 1000000;
   localparam longint ISQRT3_FX = ((longint'(57735) <<< F) + 50000) / 100000;
   localparam longint LUM_R_FX  = ((longint'(3086) <<< F) + 5000) / 10000;
   localparam longint LUM_G_FX  = ((longint'(6094) <<< F) + 5000) / 10000;
   localparam longint LUM_B_FX  = ((longint'(820) <<< F) + 5000) / 10000;

   localparam logic [31:0] ONE_V = 32'(ONE_L);

   localparam logic signed [KW-1:0]  THIRD_C  = KW'(THIRD_FX);
   localparam logic signed [KW-1:0]  ISQRT3_C = KW'(ISQRT3_FX);
   localparam logic signed [KW-1:0]  LUM_R_C  = KW'(LUM_R_FX);
   localparam logic signed [KW-1:0]  LUM_G_C  = KW'(LUM_G_FX);
   localparam logic signed [KW-1:0]  LUM_B_C  = KW'(LUM_B_FX);
   localparam logic signed [TPW-1:0] HALF_T   = TPW'(ONE_L >>> 1);
   localparam logic signed [LPW-1:0] HALF_L   = LPW'(ONE_L >>> 1);
   localparam logic signed [CW-1:0]  ONE_C    = CW'(ONE_L);
   localparam logic signed [WW-1:0]  ONE_W    = WW'(ONE_L);

   logic [HUE_WIDTH-1:0]  hue_cos_ff, hue_cos_in;
   logic [HUE_WIDTH-1:0]  hue_sin_ff, hue_sin_in;
   logic [GAIN_WIDTH-1:0] sat_gain_ff, sat_gain_in;
   logic [GAIN_WIDTH-1:0] bri_gain_ff, bri_gain_in;
   logic [GAIN_WIDTH-1:0] con_gain_ff, con_gain_in;

   logic signed [CW-1:0]   hue_a_ff, hue_a_in;
   logic signed [CW-1:0]   hue_b_ff, hue_b_in;
   logic signed [CW-1:0]   hue_c_ff, hue_c_in;
   logic signed [WW-1:0]   lum_r_ff, lum_r_in;
   logic signed [WW-1:0]   lum_g_ff, lum_g_in;
   logic signed [WW-1:0]   lum_b_ff, lum_b_in;
   logic signed [OW-1:0]   con_off_ff, con_off_in;

   logic signed [HUE_WIDTH-1:0] cos_s, sin_s;
   logic signed [CW-1:0]        one_m_cos, third_t, sin_t;
   logic signed [TPW-1:0]       third_prod, sin_prod;
   logic signed [WW-1:0]        one_m_sat, one_m_con;
   logic signed [LPW-1:0]       lum_r_prod, lum_g_prod, lum_b_prod;
   logic signed [WW+9:0]        off_base;

   // register writes
   always_comb begin
      hue_cos_in  = hue_cos_ff;
      hue_sin_in  = hue_sin_ff;
      sat_gain_in = sat_gain_ff;
      bri_gain_in = bri_gain_ff;
      con_gain_in = con_gain_ff;
      if (csr_wr.en) begin
         case (csr_wr.index)
            CSR_HUE_COS:         hue_cos_in  = csr_wr.data[HUE_WIDTH-1:0];
            CSR_HUE_SIN:         hue_sin_in  = csr_wr.data[HUE_WIDTH-1:0];
            CSR_SATURATION_GAIN: sat_gain_in = csr_wr.data[GAIN_WIDTH-1:0];
            CSR_BRIGHTNESS_GAIN: bri_gain_in = csr_wr.data[GAIN_WIDTH-1:0];
            CSR_CONTRAST_GAIN:   con_gain_in = csr_wr.data[GAIN_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // hue rotation: t = third*(1-cos), s = sin/sqrt3, a = t+cos, b = t+s, c = t-s
   always_comb begin
      cos_s      = $signed(hue_cos_ff);
      sin_s      = $signed(hue_sin_ff);
      one_m_cos  = ONE_C - CW'(cos_s);
      third_prod = one_m_cos * THIRD_C;
      sin_prod   = sin_s * ISQRT3_C;
      third_t    = CW'((third_prod + HALF_T) >>> F);
      sin_t      = CW'((sin_prod + HALF_T) >>> F);
      hue_a_in   = third_t + CW'(cos_s);
      hue_b_in   = third_t + sin_t;
      hue_c_in   = third_t - sin_t;
   end

   // saturation weights and contrast offset
   always_comb begin
      one_m_sat  = ONE_W - $signed(WW'(sat_gain_ff));
      lum_r_prod = one_m_sat * LUM_R_C;
      lum_g_prod = one_m_sat * LUM_G_C;
      lum_b_prod = one_m_sat * LUM_B_C;
      lum_r_in   = WW'((lum_r_prod + HALF_L) >>> F);
      lum_g_in   = WW'((lum_g_prod + HALF_L) >>> F);
      lum_b_in   = WW'((lum_b_prod + HALF_L) >>> F);
      // (1-con)*255*half + half of the final rounding
      one_m_con  = ONE_W - $signed(WW'(con_gain_ff));
      off_base   = ((WW+10)'(one_m_con) <<< 8) - (WW+10)'(one_m_con) + (WW+10)'(1);
      con_off_in = OW'(off_base) <<< (F - 1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_cos_ff  <= ONE_V[HUE_WIDTH-1:0];
         hue_sin_ff  <= '0;
         sat_gain_ff <= ONE_V[GAIN_WIDTH-1:0];
         bri_gain_ff <= ONE_V[GAIN_WIDTH-1:0];
         con_gain_ff <= ONE_V[GAIN_WIDTH-1:0];
      end else begin
         hue_cos_ff  <= hue_cos_in;
         hue_sin_ff  <= hue_sin_in;
         sat_gain_ff <= sat_gain_in;
         bri_gain_ff <= bri_gain_in;
         con_gain_ff <= con_gain_in;
      end
   end

   // derived coefficients are registered and follow the registers in the next cycle
   always_ff @(posedge clock) begin
      hue_a_ff   <= hue_a_in;
      hue_b_ff   <= hue_b_in;
      hue_c_ff   <= hue_c_in;
      lum_r_ff   <= lum_r_in;
      lum_g_ff   <= lum_g_in;
      lum_b_ff   <= lum_b_in;
      con_off_ff <= con_off_in;
   end

   assign hue_a    = hue_a_ff;
   assign hue_b    = hue_b_ff;
   assign hue_c    = hue_c_ff;
   assign lum_r    = lum_r_ff;
   assign lum_g    = lum_g_ff;
   assign lum_b    = lum_b_ff;
   assign sat_gain = sat_gain_ff;
   assign bri_gain = bri_gain_ff;
   assign con_gain = con_gain_ff;
   assign con_off  = con_off_ff;

endmodule

`default_nettype wire

// ===== design/color_balance_matrix_chain_core.sv =====
// ---------------------------------------------------------------------------
// color_balance_matrix_chain_core
// rgb color balance: hue rotation, saturation, brightness and contrast
// matrices in an eight-stage pipeline
// ---------------------------------------------------------------------------
//
//   channel  direction  payload                              handshake
//   -------  ---------  -----------------------------------  -------------------
//   csr      in         csr_index, csr_data                  csr_valid/csr_ready
//   req      in         req_red_in, req_green_in, req_blue_in req_valid/req_ready
//   rsp      out        rsp_red_out, rsp_green_out, rsp_blue_out rsp_valid/rsp_ready
//
// one item per clock while rsp is not stalled
// an accepted item reaches rsp through the eight register stages: input, hue matrix, saturation
//   products, saturation sum, brightness partial products, brightness sum,
//   contrast partial products, output code
// each stage holds its item only while the next one is full, so bubbles close
//   up under a stall and req_ready drops only when every stage is occupied
// reset clears the stage valid bits and loads the register defaults;
//   csr_ready and req_ready are low while reset is high
// derived coefficients are registered and follow a register write in the next cycle
//
`default_nettype none

module color_balance_matrix_chain_core #(
   parameter int COEF_FRAC_BITS = 12
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // control registers
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [cbm_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [cbm_pkg::CSR_DATA_WIDTH-1:0]  csr_data,
   // pixel in
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic [cbm_pkg::PIX_WIDTH-1:0]       req_red_in,
   input  wire logic [cbm_pkg::PIX_WIDTH-1:0]       req_green_in,
   input  wire logic [cbm_pkg::PIX_WIDTH-1:0]       req_blue_in,
   // pixel out
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [cbm_pkg::PIX_WIDTH-1:0]            rsp_red_out,
   output logic [cbm_pkg::PIX_WIDTH-1:0]            rsp_green_out,
   output logic [cbm_pkg::PIX_WIDTH-1:0]            rsp_blue_out
);
   import cbm_pkg::*;

   localparam int NUM_STAGES = 8;
   localparam int F   = COEF_FRAC_BITS;
   localparam int CW  = coef_width(F);
   localparam int WW  = weight_width(F);
   localparam int OW  = offset_width(F);
   localparam int GSW = GAIN_WIDTH + 1;       // gain as a signed operand
   localparam int P1W = CW + 10;              // hue matrix output
   localparam int GPW = P1W + GSW;            // saturation gain product
   localparam int S2W = WW + P1W + 2;         // saturation row sum
   localparam int P2W = F + 26;               // channel after a saturating stage
   localparam int SPL = 20;                   // low slice of the wide multiply
   localparam int LOW = SPL + 1 + GSW;
   localparam int HIW = P2W - SPL + GSW;
   localparam int BW  = P2W + GSW + 1;        // recombined scale product
   localparam int X3W = max_int(S2W, P2W) + 1;
   localparam int X5W = BW + 1;

   localparam longint ONE_L = longint'(1) <<< F;
   localparam longint LIM_L = longint'(1) <<< (F + 24);

   localparam logic signed [S2W-1:0] HALF_S2 = S2W'(ONE_L >>> 1);
   localparam logic signed [BW-1:0]  HALF_BW = BW'(ONE_L >>> 1);
   localparam logic signed [X3W-1:0] LIM_X3  = X3W'(LIM_L);
   localparam logic signed [X5W-1:0] LIM_X5  = X5W'(LIM_L);
   localparam logic [PIX_WIDTH-1:0]  PIX_MAX = '1;

   // coefficients
   csr_write_type         csr_wr;
   logic signed [CW-1:0]  hue_a, hue_b, hue_c;
   logic signed [WW-1:0]  lum_r, lum_g, lum_b;
   logic [GAIN_WIDTH-1:0] sat_gain, bri_gain, con_gain;
   logic signed [OW-1:0]  con_off;
   logic signed [GSW-1:0] sat_s, bri_s, con_s;

   // pipeline control
   logic [NUM_STAGES-1:0] vld_ff, vld_in;
   logic [NUM_STAGES-1:0] stage_en;

   // stage payloads, one entry per color channel
   logic [PIX_WIDTH-1:0]  pix_ff     [NUM_CH];
   logic [PIX_WIDTH-1:0]  pix_in     [NUM_CH];
   logic signed [P1W-1:0] hue_ff     [NUM_CH];
   logic signed [P1W-1:0] hue_in     [NUM_CH];
   logic signed [S2W-1:0] lum_sum_ff, lum_sum_in;
   logic signed [GPW-1:0] sat_prod_ff[NUM_CH];
   logic signed [GPW-1:0] sat_prod_in[NUM_CH];
   logic signed [P2W-1:0] bal_ff     [NUM_CH];
   logic signed [P2W-1:0] bal_in     [NUM_CH];
   logic signed [LOW-1:0] bri_lo_ff  [NUM_CH];
   logic signed [LOW-1:0] bri_lo_in  [NUM_CH];
   logic signed [HIW-1:0] bri_hi_ff  [NUM_CH];
   logic signed [HIW-1:0] bri_hi_in  [NUM_CH];
   logic signed [P2W-1:0] brt_ff     [NUM_CH];
   logic signed [P2W-1:0] brt_in     [NUM_CH];
   logic signed [LOW-1:0] con_lo_ff  [NUM_CH];
   logic signed [LOW-1:0] con_lo_in  [NUM_CH];
   logic signed [HIW-1:0] con_hi_ff  [NUM_CH];
   logic signed [HIW-1:0] con_hi_in  [NUM_CH];
   logic [PIX_WIDTH-1:0]  out_ff     [NUM_CH];
   logic [PIX_WIDTH-1:0]  out_in     [NUM_CH];

   // combinational intermediates
   logic signed [P1W-1:0] px_s       [NUM_CH];
   logic signed [S2W-1:0] bal_sum    [NUM_CH];
   logic signed [X3W-1:0] bal_x      [NUM_CH];
   logic signed [BW-1:0]  brt_sum    [NUM_CH];
   logic signed [X5W-1:0] brt_x      [NUM_CH];
   logic signed [BW-1:0]  con_sum    [NUM_CH];
   logic signed [BW-1:0]  con_code   [NUM_CH];

   // ------------------------------------------------------------------
   // control registers and coefficients
   // ------------------------------------------------------------------
   assign csr_ready    = !reset;
   assign csr_wr.en    = csr_valid && csr_ready;
   assign csr_wr.index = csr_index;
   assign csr_wr.data  = csr_data;

   cbm_coef #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
   ) u_coef (
      .clock    (clock),
      .reset    (reset),
      .csr_wr   (csr_wr),
      .hue_a    (hue_a),
      .hue_b    (hue_b),
      .hue_c    (hue_c),
      .lum_r    (lum_r),
      .lum_g    (lum_g),
      .lum_b    (lum_b),
      .sat_gain (sat_gain),
      .bri_gain (bri_gain),
      .con_gain (con_gain),
      .con_off  (con_off)
   );

   assign sat_s = $signed({1'b0, sat_gain});
   assign bri_s = $signed({1'b0, bri_gain});
   assign con_s = $signed({1'b0, con_gain});

   // ------------------------------------------------------------------
   // pipeline flow: a stage moves when it is empty or its successor moves
   // ------------------------------------------------------------------
   always_comb begin
      stage_en[NUM_STAGES-1] = !vld_ff[NUM_STAGES-1] || rsp_ready;
      for (int k = NUM_STAGES - 2; k >= 0; k--) begin
         stage_en[k] = !vld_ff[k] || stage_en[k+1];
      end
   end

   assign req_ready = stage_en[0] && !reset;

   always_comb begin
      vld_in[0] = stage_en[0] ? (req_valid && req_ready) : vld_ff[0];
      for (int k = 1; k < NUM_STAGES; k++) begin
         vld_in[k] = stage_en[k] ? vld_ff[k-1] : vld_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   // ------------------------------------------------------------------
   // datapath
   // ------------------------------------------------------------------
   always_comb begin
      // input capture
      pix_in[0] = req_red_in;
      pix_in[1] = req_green_in;
      pix_in[2] = req_blue_in;

      // hue matrix: integer pixels times F-fraction coefficients give the
      // rounded result exactly, so no rounding is needed here; the
      // row sums stay far inside the stage limit
      for (int c = 0; c < NUM_CH; c++) begin
         px_s[c] = $signed(P1W'(pix_ff[c]));
      end
      hue_in[0] = P1W'(hue_a * px_s[0]) + P1W'(hue_b * px_s[1]) + P1W'(hue_c * px_s[2]);
      hue_in[1] = P1W'(hue_c * px_s[0]) + P1W'(hue_a * px_s[1]) + P1W'(hue_b * px_s[2]);
      hue_in[2] = P1W'(hue_b * px_s[0]) + P1W'(hue_c * px_s[1]) + P1W'(hue_a * px_s[2]);

      // saturation products: shared luminance term plus per-channel gain
      lum_sum_in = S2W'(lum_r * hue_ff[0]) + S2W'(lum_g * hue_ff[1])
                 + S2W'(lum_b * hue_ff[2]);
      for (int c = 0; c < NUM_CH; c++) begin
         sat_prod_in[c] = GPW'(sat_s * hue_ff[c]);
      end

      for (int c = 0; c < NUM_CH; c++) begin
         // saturation row: round once, then stage limit
         bal_sum[c] = lum_sum_ff + S2W'(sat_prod_ff[c]) + HALF_S2;
         bal_x[c]   = X3W'(bal_sum[c] >>> F);
         if (bal_x[c] > LIM_X3) begin
            bal_in[c] = P2W'(LIM_X3);
         end else if (bal_x[c] < -LIM_X3) begin
            bal_in[c] = P2W'(-LIM_X3);
         end else begin
            bal_in[c] = P2W'(bal_x[c]);
         end

         // brightness: wide operand split into a low unsigned slice and a
         // signed high slice
         bri_lo_in[c] = LOW'(bri_s * $signed({1'b0, bal_ff[c][SPL-1:0]}));
         bri_hi_in[c] = HIW'(bri_s * $signed(bal_ff[c][P2W-1:SPL]));

         brt_sum[c] = (BW'(bri_hi_ff[c]) <<< SPL) + BW'(bri_lo_ff[c]) + HALF_BW;
         brt_x[c]   = X5W'(brt_sum[c] >>> F);
         if (brt_x[c] > LIM_X5) begin
            brt_in[c] = P2W'(LIM_X5);
         end else if (brt_x[c] < -LIM_X5) begin
            brt_in[c] = P2W'(-LIM_X5);
         end else begin
            brt_in[c] = P2W'(brt_x[c]);
         end

         // contrast partial products
         con_lo_in[c] = LOW'(con_s * $signed({1'b0, brt_ff[c][SPL-1:0]}));
         con_hi_in[c] = HIW'(con_s * $signed(brt_ff[c][P2W-1:SPL]));

         // contrast sum with offset and rounding half; the stage limit
         // cannot change the final clamp, so the code comes straight from
         // the sum: negative gives zero, above full scale gives the max
         con_sum[c]  = (BW'(con_hi_ff[c]) <<< SPL) + BW'(con_lo_ff[c]) + BW'(con_off);
         con_code[c] = con_sum[c] >>> (2 * F);
         if (con_sum[c][BW-1]) begin
            out_in[c] = '0;
         end else if (|con_code[c][BW-1:PIX_WIDTH]) begin
            out_in[c] = PIX_MAX;
         end else begin
            out_in[c] = con_code[c][PIX_WIDTH-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) pix_ff <= pix_in;
      if (stage_en[1]) hue_ff <= hue_in;
      if (stage_en[2]) begin
         lum_sum_ff  <= lum_sum_in;
         sat_prod_ff <= sat_prod_in;
      end
      if (stage_en[3]) bal_ff <= bal_in;
      if (stage_en[4]) begin
         bri_lo_ff <= bri_lo_in;
         bri_hi_ff <= bri_hi_in;
      end
      if (stage_en[5]) brt_ff <= brt_in;
      if (stage_en[6]) begin
         con_lo_ff <= con_lo_in;
         con_hi_ff <= con_hi_in;
      end
      if (stage_en[7]) out_ff <= out_in;
   end

   assign rsp_valid     = vld_ff[NUM_STAGES-1];
   assign rsp_red_out   = out_ff[0];
   assign rsp_green_out = out_ff[1];
   assign rsp_blue_out  = out_ff[2];

   // ------------------------------------------------------------------
   // assertions
   // ------------------------------------------------------------------

   // a full pipeline with a stalled output takes nothing new
   a_full_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (&vld_ff && !rsp_ready) |-> !req_ready)
      else $error("item accepted into a full stalled pipeline");

   // an accepted item lands in the first stage
   a_accept_enters : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted item missing from the input stage");

   // with nothing entering or leaving, the number of items in flight holds
   a_items_conserved : assert property (@(posedge clock) disable iff (reset)
      (!(req_valid && req_ready) && !(rsp_valid && rsp_ready))
      |=> ($countones(vld_ff) == $past($countones(vld_ff))))
      else $error("item lost or duplicated inside the pipeline");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the color balance matrix chain: a predictor of
// the hue, saturation, brightness and contrast stages in 12-bit fixed point
// is checked field by field against every pixel that leaves the core, over
// directed corner cases, a long backpressure stretch and a randomized sweep
// of register settings with random idling on both pixel channels
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

   import cbm_pkg::*;

   // fixed point format of the coefficients and of the pixel code units
   localparam int     FRAC       = 12;
   localparam longint UNIT       = longint'(1) << FRAC;
   localparam longint HALF_LSB   = longint'(1) << (FRAC - 1);
   localparam longint THIRD_Q    = ((longint'(333333) << FRAC) + 500000) / 1000000;
   localparam longint ISQRT3_Q   = ((longint'(57735) << FRAC) + 50000) / 100000;
   localparam longint LUM_R_Q    = ((longint'(3086) << FRAC) + 5000) / 10000;
   localparam longint LUM_G_Q    = ((longint'(6094) << FRAC) + 5000) / 10000;
   localparam longint LUM_B_Q    = ((longint'(820) << FRAC) + 5000) / 10000;
   localparam longint STAGE_MAX  = longint'(1) << (FRAC + 24);
   localparam int     PIX_MAX    = (1 << PIX_WIDTH) - 1;
   localparam int     DATA_MAX   = (1 << CSR_DATA_WIDTH) - 1;
   localparam int     INDEX_MAX  = (1 << CSR_INDEX_WIDTH) - 1;

   // register ranges from the register map, 1.0 = 4096
   localparam int     GAIN_ONE   = 4096;
   localparam int     HUE_LOW    = -4096;
   localparam int     HUE_HIGH   = 4096;
   localparam int     SAT_HIGH   = 20480;
   localparam int     BRIGHT_HIGH = 32767;
   localparam int     CONTRAST_HIGH = 20480;

   // run control
   localparam int     DRAIN_CYCLES  = 16;     // eight stages, with margin
   localparam int     SWEEP_PHASES  = 12;
   localparam int     PHASE_ITEMS   = 148;
   localparam int     HOLD_CYCLES   = 60;
   localparam int     MAX_REPORTS   = 60;
   localparam longint TIMEOUT_NS    = 4_000_000;

   typedef struct packed {
      logic [PIX_WIDTH-1:0] red;
      logic [PIX_WIDTH-1:0] green;
      logic [PIX_WIDTH-1:0] blue;
   } pixel_rgb_type;

   // dut ports, the ones the bench drives known from time zero
   logic                       clock         = 1'b0;
   logic                       reset         = 1'b1;
   logic                       csr_valid     = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index     = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_data      = '0;
   logic                       req_valid     = 1'b0;
   logic                       req_ready;
   logic [PIX_WIDTH-1:0]       req_red_in    = '0;
   logic [PIX_WIDTH-1:0]       req_green_in  = '0;
   logic [PIX_WIDTH-1:0]       req_blue_in   = '0;
   logic                       rsp_valid;
   logic                       rsp_ready     = 1'b0;
   logic [PIX_WIDTH-1:0]       rsp_red_out;
   logic [PIX_WIDTH-1:0]       rsp_green_out;
   logic [PIX_WIDTH-1:0]       rsp_blue_out;

   // shadow copy of the control registers, as the core holds them
   logic [HUE_WIDTH-1:0]       shadow_hue_cos;
   logic [HUE_WIDTH-1:0]       shadow_hue_sin;
   logic [GAIN_WIDTH-1:0]      shadow_saturation;
   logic [GAIN_WIDTH-1:0]      shadow_brightness;
   logic [GAIN_WIDTH-1:0]      shadow_contrast;

   // predicted pixels in the order their inputs were accepted
   pixel_rgb_type              expected_pixels[$];

   int                         fail_count    = 0;
   int                         report_count  = 0;
   int                         send_idle_pct = 10;
   int                         recv_idle_pct = 84;
   int                         hold_request  = 0;
   int                         hold_left     = 0;

   color_balance_matrix_chain_core #(
      .COEF_FRAC_BITS (FRAC)
   ) dut (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_red_in    (req_red_in),
      .req_green_in  (req_green_in),
      .req_blue_in   (req_blue_in),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_red_out   (rsp_red_out),
      .rsp_green_out (rsp_green_out),
      .rsp_blue_out  (rsp_blue_out)
   );

   // 8 ns clock
   initial begin
      forever #4 clock = ~clock;
   end

   // hard stop in case the core hangs
   initial begin
      #(TIMEOUT_NS);
      $display("FAIL color_balance_matrix_chain_core");
      $finish;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // round to nearest at the coefficient lsb, halves go up (floor of x + 1/2)
   function automatic longint round_frac(input longint v);
      return (v + HALF_LSB) >>> FRAC;
   endfunction

   // per-stage saturation, only reachable with out-of-range registers
   function automatic longint clip_stage(input longint v);
      if (v > STAGE_MAX)
         return STAGE_MAX;
      if (v < -STAGE_MAX)
         return -STAGE_MAX;
      return v;
   endfunction

   // drop the fraction and clamp into an 8-bit code
   function automatic logic [PIX_WIDTH-1:0] to_pixel_code(input longint v);
      longint whole;
      if (v < 0)
         return '0;
      whole = v >>> FRAC;
      return (whole > PIX_MAX) ? PIX_WIDTH'(PIX_MAX) : PIX_WIDTH'(whole);
   endfunction

   // full chain for one pixel under the current shadow registers
   function automatic pixel_rgb_type balance_pixel(input pixel_rgb_type px);
      longint        chan[3];
      longint        mix[3];
      longint        cs, sn, sg, bg, cg;
      longint        tr, sk, ha, hb, hc;
      longint        wr, wg, wb, lum, off;
      pixel_rgb_type res;
      cs = longint'($signed(shadow_hue_cos));
      sn = longint'($signed(shadow_hue_sin));
      sg = longint'(shadow_saturation);
      bg = longint'(shadow_brightness);
      cg = longint'(shadow_contrast);
      chan[0] = longint'(px.red) << FRAC;
      chan[1] = longint'(px.green) << FRAC;
      chan[2] = longint'(px.blue) << FRAC;

      // hue rotation about the grey axis, circulant matrix
      tr = round_frac(THIRD_Q * (UNIT - cs));
      sk = round_frac(ISQRT3_Q * sn);
      ha = tr + cs;
      hb = tr + sk;
      hc = tr - sk;
      mix[0] = round_frac(ha * chan[0] + hb * chan[1] + hc * chan[2]);
      mix[1] = round_frac(hc * chan[0] + ha * chan[1] + hb * chan[2]);
      mix[2] = round_frac(hb * chan[0] + hc * chan[1] + ha * chan[2]);
      foreach (chan[i])
         chan[i] = clip_stage(mix[i]);

      // saturation: shared luminance term plus the channel scaled by sat
      wr = round_frac((UNIT - sg) * LUM_R_Q);
      wg = round_frac((UNIT - sg) * LUM_G_Q);
      wb = round_frac((UNIT - sg) * LUM_B_Q);
      lum = wr * chan[0] + wg * chan[1] + wb * chan[2];
      foreach (mix[i])
         mix[i] = round_frac(lum + sg * chan[i]);
      foreach (chan[i])
         chan[i] = clip_stage(mix[i]);

      // brightness
      foreach (chan[i])
         chan[i] = clip_stage(round_frac(bg * chan[i]));

      // contrast about mid grey: (1 - c) * 255/2 added before the one rounding
      off = (UNIT - cg) * PIX_MAX * HALF_LSB;
      foreach (chan[i])
         chan[i] = clip_stage(round_frac(cg * chan[i] + off));

      res.red   = to_pixel_code(chan[0]);
      res.green = to_pixel_code(chan[1]);
      res.blue  = to_pixel_code(chan[2]);
      return res;
   endfunction

   // register write as the core applies it; unknown indexes change nothing
   function automatic void apply_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                     input logic [CSR_DATA_WIDTH-1:0] data);
      case (idx)
         CSR_HUE_COS:         shadow_hue_cos    = data[HUE_WIDTH-1:0];
         CSR_HUE_SIN:         shadow_hue_sin    = data[HUE_WIDTH-1:0];
         CSR_SATURATION_GAIN: shadow_saturation = data[GAIN_WIDTH-1:0];
         CSR_BRIGHTNESS_GAIN: shadow_brightness = data[GAIN_WIDTH-1:0];
         CSR_CONTRAST_GAIN:   shadow_contrast   = data[GAIN_WIDTH-1:0];
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // result side: ready pattern and checking
   // ------------------------------------------------------------------

   // ready is random per cycle, except during a requested long hold-off
   always @(posedge clock) begin
      if (hold_request > 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic check_field(input string field, input logic [PIX_WIDTH-1:0] want,
                              input logic [PIX_WIDTH-1:0] got);
      if (got !== want) begin
         fail_count++;
         if (report_count < MAX_REPORTS)
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
         report_count++;
      end
   endtask

   // every accepted pixel is compared with the oldest prediction
   always @(posedge clock) begin : check_results
      pixel_rgb_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_pixels.size() == 0) begin
            fail_count++;
            if (report_count < MAX_REPORTS)
               $error("unexpected result item %0d %0d %0d",
                      rsp_red_out, rsp_green_out, rsp_blue_out);
            report_count++;
         end else begin
            want = expected_pixels.pop_front();
            check_field("red_out", want.red, rsp_red_out);
            check_field("green_out", want.green, rsp_green_out);
            check_field("blue_out", want.blue, rsp_blue_out);
         end
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   // offer one pixel after a random gap; valid stays up until accepted
   task automatic send_rgb(input logic [PIX_WIDTH-1:0] r, input logic [PIX_WIDTH-1:0] g,
                           input logic [PIX_WIDTH-1:0] b);
      pixel_rgb_type px;
      px = '{red: r, green: g, blue: b};
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_red_in   <= r;
      req_green_in <= g;
      req_blue_in  <= b;
      do
         @(posedge clock);
      while (!req_ready);
      expected_pixels.push_back(balance_pixel(px));
   endtask

   // stop offering and let every predicted pixel come out
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (expected_pixels.size() != 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do
         @(posedge clock);
      while (!csr_ready);
      apply_csr(idx, data);
   endtask

   // reprogram all five registers once the core is empty
   task automatic configure(input int cos_v, input int sin_v, input int sat_v,
                            input int bright_v, input int contrast_v);
      wait_for_results();
      write_csr(CSR_HUE_COS, CSR_DATA_WIDTH'(cos_v));
      write_csr(CSR_HUE_SIN, CSR_DATA_WIDTH'(sin_v));
      write_csr(CSR_SATURATION_GAIN, CSR_DATA_WIDTH'(sat_v));
      write_csr(CSR_BRIGHTNESS_GAIN, CSR_DATA_WIDTH'(bright_v));
      write_csr(CSR_CONTRAST_GAIN, CSR_DATA_WIDTH'(contrast_v));
      csr_valid <= 1'b0;
   endtask

   // channel value with the two extremes weighted up
   function automatic logic [PIX_WIDTH-1:0] random_channel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return PIX_WIDTH'(PIX_MAX);
         default: return PIX_WIDTH'($urandom_range(PIX_MAX));
      endcase
   endfunction

   // hue register: range ends, zero, in-range values, now and then any pattern
   function automatic int random_hue();
      case ($urandom_range(6))
         0:       return HUE_LOW;
         1:       return HUE_HIGH;
         2:       return 0;
         6:       return int'($urandom_range(DATA_MAX));
         default: return int'($urandom_range(HUE_HIGH - HUE_LOW)) + HUE_LOW;
      endcase
   endfunction

   // gain register: zero, top of range, unity, anywhere in range, any pattern, else near unity
   function automatic int random_gain(input int top);
      case ($urandom_range(7))
         0:       return 0;
         1:       return top;
         2:       return GAIN_ONE;
         3:       return int'($urandom_range(top));
         7:       return int'($urandom_range(DATA_MAX));
         default: return int'($urandom_range(2 * GAIN_ONE, GAIN_ONE / 2));
      endcase
   endfunction

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // register defaults straight out of reset: identity chain
   task automatic test_reset_defaults();
      send_rgb(8'd0, 8'd0, 8'd0);
      send_rgb(8'd255, 8'd255, 8'd255);
      send_rgb(8'd255, 8'd0, 8'd0);
      send_rgb(8'd0, 8'd255, 8'd0);
      send_rgb(8'd0, 8'd0, 8'd255);
      send_rgb(8'h55, 8'hAA, 8'h80);
      send_rgb(8'hAA, 8'h55, 8'h7F);
   endtask

   // high contrast drives dark pixels negative and bright ones past 255
   task automatic test_clipping();
      configure(HUE_HIGH, 0, GAIN_ONE, GAIN_ONE, CONTRAST_HIGH);
      send_rgb(8'd0, 8'd0, 8'd0);
      send_rgb(8'd255, 8'd255, 8'd255);
      send_rgb(8'd20, 8'd200, 8'd100);
      send_rgb(8'd127, 8'd128, 8'd129);
      // all gains zero: everything collapses to mid grey
      configure(HUE_LOW, HUE_HIGH, 0, 0, 0);
      send_rgb(8'd255, 8'd10, 8'd0);
   endtask

   // writes to indexes past the register map leave every register alone
   task automatic test_unknown_index();
      configure(2048, 3547, 6144, 3000, 5000);
      @(posedge clock);
      for (int idx = int'(CSR_CONTRAST_GAIN) + 1; idx <= INDEX_MAX; idx++)
         write_csr(CSR_INDEX_WIDTH'(idx), CSR_DATA_WIDTH'($urandom_range(DATA_MAX)));
      csr_valid <= 1'b0;
      send_rgb(8'd200, 8'd50, 8'd90);
      send_rgb(8'd1, 8'd254, 8'd128);
      send_rgb(8'd255, 8'd255, 8'd0);
   endtask

   // registers far outside their ranges push the stages into saturation;
   // bit 14 of the hue writes must be dropped
   task automatic test_register_overflow();
      configure(-8192, 8191, DATA_MAX, DATA_MAX, DATA_MAX);
      send_rgb(8'd255, 8'd255, 8'd255);
      send_rgb(8'd255, 8'd0, 8'd0);
      send_rgb(8'd0, 8'd0, 8'd0);
      configure(8191, -8192, DATA_MAX, 0, DATA_MAX);
      send_rgb(8'd0, 8'd255, 8'd0);
      send_rgb(8'd0, 8'd0, 8'd255);
   endtask

   // result side stalls for a long stretch while pixels keep coming, so every
   // stage fills and req_ready has to drop; then the sender waits it out
   task automatic test_backpressure();
      int saved_send;
      int saved_recv;
      saved_send = send_idle_pct;
      saved_recv = recv_idle_pct;
      configure(random_hue(), random_hue(), GAIN_ONE, 5000, 3000);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_request = HOLD_CYCLES;
      repeat (40)
         send_rgb(random_channel(), random_channel(), random_channel());
      wait_for_results();
      send_idle_pct = saved_send;
      recv_idle_pct = saved_recv;
   endtask

   // random register settings, a batch of random pixels under each;
   // first third sender lightly idle / receiver mostly idle, then reversed,
   // then both flat out
   task automatic test_random_sweep();
      for (int phase = 0; phase < SWEEP_PHASES; phase++) begin
         case (phase * 3 / SWEEP_PHASES)
            0: begin
               send_idle_pct = 10;
               recv_idle_pct = 84;
            end
            1: begin
               send_idle_pct = 84;
               recv_idle_pct = 10;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         configure(random_hue(), random_hue(), random_gain(SAT_HIGH),
                   random_gain(BRIGHT_HIGH), random_gain(CONTRAST_HIGH));
         repeat (PHASE_ITEMS)
            send_rgb(random_channel(), random_channel(), random_channel());
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      // shadow registers start at the reset values of the core
      shadow_hue_cos    = HUE_WIDTH'(GAIN_ONE);
      shadow_hue_sin    = '0;
      shadow_saturation = GAIN_WIDTH'(GAIN_ONE);
      shadow_brightness = GAIN_WIDTH'(GAIN_ONE);
      shadow_contrast   = GAIN_WIDTH'(GAIN_ONE);

      repeat (3)
         @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_clipping();
      test_unknown_index();
      test_register_overflow();
      test_backpressure();
      test_random_sweep();

      // let the pipeline empty, then wait on for stray results
      wait_for_results();
      repeat (DRAIN_CYCLES)
         @(posedge clock);
      if (fail_count == 0)
         $display("PASS color_balance_matrix_chain_core");
      else
         $display("FAIL color_balance_matrix_chain_core");
      $finish;
   end

endmodule
